@@ design/assert_macros.svh @@
// Assertion helpers shared by the blitter modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BLT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define BLT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bitblt_pkg.sv @@
package bitblt_pkg;

    // Store geometry.
    localparam int MAX_W = 64;
    localparam int MAX_H = 64;
    localparam int DEPTH = MAX_W * MAX_H;
    localparam int XB = $clog2(MAX_W);
    localparam int YB = $clog2(MAX_H);
    localparam int WB = $clog2(MAX_W + 1);
    localparam int HB = $clog2(MAX_H + 1);
    localparam int AB = $clog2(DEPTH);

    // Field widths.
    localparam int PIX_W = 32;
    localparam int CRD_W = 16;
    localparam int CB = CRD_W + 2;
    localparam int DIM_W = 7;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int HT_REGS = 4;

    localparam logic [PIX_W-1:0] PAINT_MASK = 32'h00FF_FFFF;

    // Raster operations; codes above paint act as copy.
    localparam logic [2:0] ROP_COPY = 3'd0;
    localparam logic [2:0] ROP_OR = 3'd1;
    localparam logic [2:0] ROP_AND = 3'd2;
    localparam logic [2:0] ROP_XOR = 3'd3;
    localparam logic [2:0] ROP_PAINT = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HT0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HT1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HT2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HT3 = 3'd7;

    typedef enum logic [1:0] {
        OP_WR_SRC = 2'd0,
        OP_WR_DST = 2'd1,
        OP_RD_DST = 2'd2,
        OP_XFER   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        MK_NONE   = 3'd0,
        MK_WR_SRC = 3'd1,
        MK_WR_DST = 3'd2,
        MK_RD_DST = 3'd3,
        MK_PIX    = 3'd4
    } mem_kind_t;

    typedef struct packed {
        op_t                     op;
        logic signed [CRD_W-1:0] pos_x;
        logic signed [CRD_W-1:0] pos_y;
        logic signed [CRD_W-1:0] from_x;
        logic signed [CRD_W-1:0] from_y;
        logic signed [CRD_W-1:0] rect_width;
        logic signed [CRD_W-1:0] rect_height;
        logic [2:0]              raster_op;
        logic [PIX_W-1:0]        pixel_in;
    } in_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [1:0]       status;
    } out_rsp_t;

    // Active sizes are held already clamped to the store size.
    typedef struct packed {
        logic [WB-1:0]                          dest_w;
        logic [HB-1:0]                          dest_h;
        logic [WB-1:0]                          src_w;
        logic [HB-1:0]                          src_h;
        logic [HT_REGS-1:0][CFG_DATA_W-1:0]     halftone;
    } cfg_t;

    typedef struct packed {
        mem_kind_t        kind;
        logic [AB-1:0]    dst_addr;
        logic [AB-1:0]    src_addr;
        logic             src_rd;
        logic             gate;
        logic [2:0]       rop;
        logic [PIX_W-1:0] data;
    } mem_op_t;

endpackage

@@ design/bitblt_raster_op_engine.sv @@
// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_stall    in_data   (in_req_t)
// out       result     out_valid / out_stall  out_data  (out_rsp_t)
// cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A pixel access steps through setup, access, wait and result; a transfer through setup
// and check, then one clipped destination pixel per cycle through the read-modify-write
// path of the destination memory, then wait and result. A rejected or fully clipped
// transfer goes from check to result. The next request is taken in the cycle after the
// result is loaded into the output register, which may still be waiting on out_stall.
// Reset clears control state only; store entries are undefined until written.
module bitblt_raster_op_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  bitblt_pkg::in_req_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bitblt_pkg::out_rsp_t                out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bitblt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bitblt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bitblt_pkg::*;

    cfg_t             cfg;
    mem_op_t          mem_op;
    logic [PIX_W-1:0] rd_data;

    bitblt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bitblt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg       (cfg),
        .mem_op    (mem_op),
        .rd_data   (rd_data)
    );

    bitblt_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_op  (mem_op),
        .rd_data (rd_data)
    );

endmodule

@@ design/bitblt_cfg.sv @@
module bitblt_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bitblt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bitblt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bitblt_pkg::cfg_t                    cfg
);
    import bitblt_pkg::*;

    localparam int RST_DW = (64 > MAX_W) ? MAX_W : 64;
    localparam int RST_DH = (64 > MAX_H) ? MAX_H : 64;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [DIM_W-1:0] dim;
    logic [WB-1:0]    dim_w;
    logic [HB-1:0]    dim_h;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    // Sizes beyond the store behave as the store size, so clamp on write.
    always_comb
    begin
        dim = cfg_data[DIM_W-1:0];
        dim_w = (int'(dim) > MAX_W) ? WB'(MAX_W) : WB'(dim);
        dim_h = (int'(dim) > MAX_H) ? HB'(MAX_H) : HB'(dim);
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEST_W: cfg_next.dest_w = dim_w;
                CFG_DEST_H: cfg_next.dest_h = dim_h;
                CFG_SRC_W:  cfg_next.src_w = dim_w;
                CFG_SRC_H:  cfg_next.src_h = dim_h;
                CFG_HT0:    cfg_next.halftone[0] = cfg_data;
                CFG_HT1:    cfg_next.halftone[1] = cfg_data;
                CFG_HT2:    cfg_next.halftone[2] = cfg_data;
                CFG_HT3:    cfg_next.halftone[3] = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_w <= WB'(RST_DW);
            cfg_reg.dest_h <= HB'(RST_DH);
            cfg_reg.src_w <= '0;
            cfg_reg.src_h <= '0;
            cfg_reg.halftone <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/bitblt_store.sv @@
`include "assert_macros.svh"

module bitblt_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bitblt_pkg::mem_op_t           mem_op,
    output logic [bitblt_pkg::PIX_W-1:0]  rd_data
);
    import bitblt_pkg::*;

    logic [PIX_W-1:0] src_mem [0:DEPTH-1];
    logic [PIX_W-1:0] dst_mem [0:DEPTH-1];

    logic [PIX_W-1:0] src_q;
    logic [PIX_W-1:0] dst_q;

    // Write-back stage of a transfer pixel.
    logic             pix_valid_reg;
    logic [AB-1:0]    pix_addr_reg;
    logic             pix_src_rd_reg;
    logic             pix_gate_reg;
    logic [2:0]       pix_rop_reg;

    logic [PIX_W-1:0] s_fetch;
    logic [PIX_W-1:0] s_val;
    logic [PIX_W-1:0] rop_res;

    always_ff @(posedge clk)
    begin
        if (mem_op.kind == MK_WR_SRC)
        begin
            src_mem[mem_op.src_addr] <= mem_op.data;
        end
        if (mem_op.kind == MK_PIX && mem_op.src_rd)
        begin
            src_q <= src_mem[mem_op.src_addr];
        end
    end

    // The sequencer never issues a destination write while a pixel is in
    // write-back, and consecutive transfer pixels have distinct addresses.
    always_ff @(posedge clk)
    begin
        if (pix_valid_reg)
        begin
            dst_mem[pix_addr_reg] <= rop_res;
        end
        else if (mem_op.kind == MK_WR_DST)
        begin
            dst_mem[mem_op.dst_addr] <= mem_op.data;
        end
        if (mem_op.kind == MK_RD_DST || mem_op.kind == MK_PIX)
        begin
            dst_q <= dst_mem[mem_op.dst_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= (mem_op.kind == MK_PIX);
        end
    end

    always_ff @(posedge clk)
    begin
        pix_addr_reg <= mem_op.dst_addr;
        pix_src_rd_reg <= mem_op.src_rd;
        pix_gate_reg <= mem_op.gate;
        pix_rop_reg <= mem_op.rop;
    end

    always_comb
    begin
        s_fetch = pix_src_rd_reg ? src_q : '1;
        s_val = pix_gate_reg ? s_fetch : '0;
        case (pix_rop_reg)
            ROP_OR:    rop_res = dst_q | s_val;
            ROP_AND:   rop_res = dst_q & s_val;
            ROP_XOR:   rop_res = dst_q ^ s_val;
            ROP_PAINT: rop_res = ((s_val & PAINT_MASK) != '0) ? s_val : dst_q;
            default:   rop_res = s_val;
        endcase
    end

    assign rd_data = dst_q;

    `BLT_ASSERT(a_no_write_clash, !pix_valid_reg || (mem_op.kind != MK_WR_DST),
        "destination write issued during pixel write-back")
    `BLT_ASSERT_NEXT(a_no_raw_overlap, mem_op.kind == MK_PIX,
        (mem_op.kind != MK_PIX) || (mem_op.dst_addr != $past(mem_op.dst_addr)),
        "pixel read of an address still in write-back")

endmodule

@@ design/bitblt_seq.sv @@
`include "assert_macros.svh"

module bitblt_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bitblt_pkg::in_req_t           in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bitblt_pkg::out_rsp_t          out_data,
    input  bitblt_pkg::cfg_t              cfg,
    output bitblt_pkg::mem_op_t           mem_op,
    input  logic [bitblt_pkg::PIX_W-1:0]  rd_data
);
    import bitblt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_ACC   = 7'b0001000,
        S_RUN   = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t   state_reg;
    state_t   state_next;
    in_req_t  req_reg;
    logic [1:0] status_reg;
    logic [1:0] status_next;
    out_rsp_t out_reg;
    out_rsp_t out_next;
    logic     out_valid_reg;
    logic     out_valid_next;

    // Access request.
    logic          acc_ok_reg;
    logic [AB-1:0] acc_addr_reg;

    // Transfer bounds in destination coordinates, end exclusive.
    logic signed [CB-1:0] ylo_reg;
    logic signed [CB-1:0] yhi_reg;
    logic signed [CB-1:0] xlo_reg;
    logic signed [CB-1:0] xhi_reg;
    logic signed [CB-1:0] dsx_reg;
    logic signed [CB-1:0] dsy_reg;
    logic                 reject_reg;

    // Pixel walk.
    logic [YB-1:0]        y_reg;
    logic [XB-1:0]        x_reg;
    logic [XB-1:0]        xstart_reg;
    logic [XB:0]          xend_reg;
    logic [YB:0]          yend_reg;
    logic signed [CB-1:0] sx_reg;
    logic signed [CB-1:0] sy_reg;
    logic signed [CB-1:0] sx_start_reg;

    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
    logic signed [CB-1:0] fx;
    logic signed [CB-1:0] fy;
    logic signed [CB-1:0] rw;
    logic signed [CB-1:0] rh;
    logic signed [CB-1:0] dw_s;
    logic signed [CB-1:0] dh_s;
    logic signed [CB-1:0] sw_s;
    logic signed [CB-1:0] sh_s;
    logic signed [CB-1:0] xsum;
    logic signed [CB-1:0] ysum;
    logic [WB-1:0]        acc_w;
    logic [HB-1:0]        acc_h;
    logic                 acc_ok_c;
    logic [AB-1:0]        acc_addr_c;
    logic                 empty;
    logic                 src_hit;
    logic [3:0]           ht_row;
    logic [XB:0]          x_inc;
    logic [YB:0]          y_inc;
    logic                 x_last;
    logic                 y_last;
    logic                 out_free;
    logic                 accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        px = CB'(req_reg.pos_x);
        py = CB'(req_reg.pos_y);
        fx = CB'(req_reg.from_x);
        fy = CB'(req_reg.from_y);
        rw = CB'(req_reg.rect_width);
        rh = CB'(req_reg.rect_height);
        dw_s = $signed(CB'(cfg.dest_w));
        dh_s = $signed(CB'(cfg.dest_h));
        sw_s = $signed(CB'(cfg.src_w));
        sh_s = $signed(CB'(cfg.src_h));
        xsum = px + rw;
        ysum = py + rh;

        acc_w = (req_reg.op == OP_WR_SRC) ? cfg.src_w : cfg.dest_w;
        acc_h = (req_reg.op == OP_WR_SRC) ? cfg.src_h : cfg.dest_h;
        acc_ok_c = (px >= 0) && (px < $signed(CB'(acc_w)))
            && (py >= 0) && (py < $signed(CB'(acc_h)));
        acc_addr_c = AB'(req_reg.pos_y[YB-1:0]) * AB'(acc_w) + AB'(req_reg.pos_x[XB-1:0]);

        empty = (ylo_reg >= yhi_reg) || (xlo_reg >= xhi_reg);

        src_hit = (sx_reg >= 0) && (sx_reg < sw_s) && (sy_reg >= 0) && (sy_reg < sh_s);
        ht_row = y_reg[3:0];
        x_inc = {1'b0, x_reg} + 1'b1;
        y_inc = {1'b0, y_reg} + 1'b1;
        x_last = (x_inc == xend_reg);
        y_last = (y_inc == yend_reg);
    end

    // Memory request for the current cycle.
    always_comb
    begin
        mem_op.kind = MK_NONE;
        mem_op.dst_addr = acc_addr_reg;
        mem_op.src_addr = acc_addr_reg;
        mem_op.src_rd = 1'b0;
        mem_op.gate = 1'b0;
        mem_op.rop = req_reg.raster_op;
        mem_op.data = req_reg.pixel_in;
        if (state_reg == S_ACC && acc_ok_reg)
        begin
            unique case (req_reg.op)
                OP_WR_SRC: mem_op.kind = MK_WR_SRC;
                OP_WR_DST: mem_op.kind = MK_WR_DST;
                OP_RD_DST: mem_op.kind = MK_RD_DST;
                default:   mem_op.kind = MK_NONE;
            endcase
        end
        else if (state_reg == S_RUN)
        begin
            mem_op.kind = MK_PIX;
            mem_op.dst_addr = AB'(y_reg) * AB'(cfg.dest_w) + AB'(x_reg);
            mem_op.src_addr = AB'(sy_reg[YB-1:0]) * AB'(cfg.src_w) + AB'(sx_reg[XB-1:0]);
            mem_op.src_rd = src_hit;
            mem_op.gate = cfg.halftone[ht_row[3:2]][{ht_row[1:0], x_reg[3:0]}];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        status_next = status_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                status_next = acc_ok_c ? ST_DONE : ST_OUTSIDE;
                state_next = (req_reg.op == OP_XFER) ? S_CHECK : S_ACC;
            end
            S_CHECK:
            begin
                status_next = reject_reg ? ST_REJECT : ST_DONE;
                state_next = (reject_reg || empty) ? S_DONE : S_RUN;
            end
            S_ACC:
            begin
                state_next = S_WAIT;
            end
            S_RUN:
            begin
                if (x_last && y_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next.status = status_reg;
                    out_next.pixel_out =
                        (req_reg.op == OP_RD_DST && status_reg == ST_DONE) ? rd_data : '0;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            status_reg <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            status_reg <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept)
        begin
            req_reg <= in_data;
        end
        if (state_reg == S_SETUP)
        begin
            acc_ok_reg <= acc_ok_c;
            acc_addr_reg <= acc_addr_c;
            reject_reg <= (rw <= 0) || (rh <= 0);
            ylo_reg <= (py < 0) ? '0 : py;
            xlo_reg <= (px < 0) ? '0 : px;
            yhi_reg <= (ysum > dh_s) ? dh_s : ysum;
            xhi_reg <= (xsum > dw_s) ? dw_s : xsum;
            dsx_reg <= fx - px;
            dsy_reg <= fy - py;
        end
        if (state_reg == S_CHECK)
        begin
            // Bounds are inside the destination whenever the walk is entered.
            y_reg <= ylo_reg[YB-1:0];
            x_reg <= xlo_reg[XB-1:0];
            xstart_reg <= xlo_reg[XB-1:0];
            xend_reg <= xhi_reg[XB:0];
            yend_reg <= yhi_reg[YB:0];
            sx_reg <= xlo_reg + dsx_reg;
            sx_start_reg <= xlo_reg + dsx_reg;
            sy_reg <= ylo_reg + dsy_reg;
        end
        if (state_reg == S_RUN)
        begin
            if (x_last)
            begin
                x_reg <= xstart_reg;
                sx_reg <= sx_start_reg;
                y_reg <= y_inc[YB-1:0];
                sy_reg <= sy_reg + CB'(1);
            end
            else
            begin
                x_reg <= x_inc[XB-1:0];
                sx_reg <= sx_reg + CB'(1);
            end
        end
    end

    `BLT_ASSERT(a_walk_in_rect, (state_reg != S_RUN)
        || (((XB+1)'(x_reg) < xend_reg) && ((YB+1)'(y_reg) < yend_reg)),
        "pixel walk left the clipped rectangle")
    `BLT_ASSERT(a_done_entry,
        (state_reg != S_DONE) || ($past(state_reg) == S_DONE)
        || ($past(state_reg) == S_WAIT) || ($past(state_reg) == S_CHECK),
        "result state entered without finishing the request")
    `BLT_ASSERT(a_result_source, !$rose(out_valid_reg) || ($past(state_reg) == S_DONE),
        "result presented outside the result state")

endmodule
